// ===== rtl/core/rcp_pkg.sv =====
// Shared types and constants of the request coordinate parser.
package rcp_pkg;

  // Field and state widths.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MANT_W = 51;
  localparam int unsigned ACC_W  = 50;
  localparam int unsigned FRAC_W = 4;
  localparam int unsigned Z_W    = 31;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned STAT_W = 2;

  // Digit limits for the X and Y numbers and for the Z integer.
  localparam logic [CNT_W-1:0] MAX_DIGITS     = CNT_W'(15);
  localparam logic [CNT_W-1:0] MAX_INT_DIGITS = CNT_W'(9);

  // Characters that steer the parse.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_Y     = 8'h59;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Bits of the status field.
  localparam int unsigned STAT_DROPPED = 0;
  localparam int unsigned STAT_MISSING = 1;

  // Parse phase.
  typedef enum logic [2:0] {
    PH_SLASH  = 3'd0,
    PH_SEEK_X = 3'd1,
    PH_READ_X = 3'd2,
    PH_SEEK_Y = 3'd3,
    PH_READ_Y = 3'd4,
    PH_SEEK_Z = 3'd5,
    PH_READ_Z = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

endpackage

// ===== rtl/core/rcp_char_if.sv =====
// Byte channel into the request coordinate parser.
interface rcp_char_if;
  logic                          valid;
  logic                          ready;
  logic [rcp_pkg::CHAR_W-1:0]    char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/core/rcp_coord_if.sv =====
// Result channel of the request coordinate parser.
interface rcp_coord_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcp_pkg::MANT_W-1:0]   x_mantissa;
  logic        [rcp_pkg::FRAC_W-1:0]   x_frac_digits;
  logic signed [rcp_pkg::MANT_W-1:0]   y_mantissa;
  logic        [rcp_pkg::FRAC_W-1:0]   y_frac_digits;
  logic signed [rcp_pkg::Z_W-1:0]      z_value;
  logic        [rcp_pkg::STAT_W-1:0]   parse_status;

  modport source (output valid, output x_mantissa, output x_frac_digits, output y_mantissa,
                  output y_frac_digits, output z_value, output parse_status, input ready);
  modport sink   (input valid, input x_mantissa, input x_frac_digits, input y_mantissa,
                  input y_frac_digits, input z_value, input parse_status, output ready);
endinterface

// ===== rtl/core/request_coordinate_parser.sv =====
// Request coordinate parser: byte stream in, one X/Y/Z coordinate result per request out.
//
// Usage:
//   char_i carries one request byte per item. Bytes before the first '/' are
//   skipped; then the X, Y and Z markers are searched in turn and the numbers
//   behind them are read. A zero byte closes the request and yields one item
//   on coord_o; all other bytes yield none.
//   X and Y come out as a signed decimal mantissa and a count of fraction
//   digits, Z as a signed integer. parse_status bit 0 flags dropped digits,
//   bit 1 a missing marker.
// Timing:
//   One byte is taken every cycle unless a zero byte stalls (see below). A
//   byte sits in the input register, then the parse state and the result
//   register are updated, so the result of a zero byte leaves from the result register.
//   The per-byte path is one multiply-by-ten-and-add on the 50-bit accumulator.
// Reset:
//   Reset empties both registers and returns the parser to the search for '/'.
// Stall:
//   While a result waits on coord_o, bytes keep flowing in; only a further
//   zero byte halts in the input register until the waiting result is taken.
module request_coordinate_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  rcp_char_if.sink            char_i,
  rcp_coord_if.source         coord_o
);
  import rcp_pkg::*;

  // Phase after the number being read is closed.
  function automatic phase_e finish_phase(input phase_e p);
    phase_e r;
    r = p;
    unique case (p)
      PH_READ_X: r = PH_SEEK_Y;
      PH_READ_Y: r = PH_SEEK_Z;
      PH_READ_Z: r = PH_DONE;
      default:   r = p;
    endcase
    return r;
  endfunction

  // Phase after checking a byte as the next marker.
  function automatic phase_e seek_phase(input phase_e p, input logic [CHAR_W-1:0] c);
    phase_e r;
    r = p;
    unique case (p)
      PH_SLASH:  if (c == CHAR_SLASH) r = PH_SEEK_X;
      PH_SEEK_X: if (c == CHAR_X) r = PH_READ_X;
      PH_SEEK_Y: if (c == CHAR_Y) r = PH_READ_Y;
      PH_SEEK_Z: if (c == CHAR_Z) r = PH_READ_Z;
      default:   r = p;
    endcase
    return r;
  endfunction

  // Input register.
  logic                s1_valid_q, s1_valid_d;
  logic [CHAR_W-1:0]   char_q;

  // Parse state.
  phase_e              phase_q, phase_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                start_q, start_d;
  logic                point_q, point_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [CNT_W-1:0]    dig_q, dig_d;
  logic [MANT_W-1:0]   xm_q, xm_d;
  logic [FRAC_W-1:0]   xf_q, xf_d;
  logic [MANT_W-1:0]   ym_q, ym_d;
  logic [FRAC_W-1:0]   yf_q, yf_d;
  logic [STAT_W-1:0]   flags_q, flags_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [MANT_W-1:0]   out_xm_q, out_xm_d;
  logic [FRAC_W-1:0]   out_xf_q, out_xf_d;
  logic [MANT_W-1:0]   out_ym_q, out_ym_d;
  logic [FRAC_W-1:0]   out_yf_q, out_yf_d;
  logic [Z_W-1:0]      out_z_q, out_z_d;
  logic [STAT_W-1:0]   out_st_q, out_st_d;

  // Handshake and byte decode.
  logic                in_fire, out_fire, s1_adv, s1_fire;
  logic                char_zero, reading, is_digit, sign_take, point_take, terminator;
  logic                skip_zero, at_limit, new_number;
  logic [3:0]          digit;
  logic [CNT_W-1:0]    limit;
  logic [MANT_W-1:0]   sval;
  logic [ACC_W-1:0]    acc_next;
  phase_e              seek_in, seek_out;

  // A zero byte may only leave the input register when the result register is free or being read.
  assign char_zero   = (char_q == CHAR_NUL);
  assign out_fire    = out_valid_q && coord_o.ready;
  assign s1_adv      = !char_zero || !out_valid_q || coord_o.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign char_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = char_i.valid && char_i.ready;

  // Classification of the byte in the input register.
  assign reading    = (phase_q == PH_READ_X) || (phase_q == PH_READ_Y) ||
                      (phase_q == PH_READ_Z);
  assign is_digit   = (char_q >= CHAR_ZERO) && (char_q <= CHAR_NINE);
  assign digit      = 4'(char_q - CHAR_ZERO);
  assign sign_take  = reading && start_q && (char_q == CHAR_MINUS);
  assign point_take = reading && !sign_take && (char_q == CHAR_POINT) &&
                      (phase_q != PH_READ_Z) && !point_q;
  assign terminator = reading && !sign_take && !is_digit && !point_take;
  assign skip_zero  = !point_q && (acc_q == '0) && (digit == 4'd0);
  assign limit      = (phase_q == PH_READ_Z) ? MAX_INT_DIGITS : MAX_DIGITS;
  assign at_limit   = (dig_q >= limit);
  assign acc_next   = (acc_q << 3) + (acc_q << 1) + ACC_W'(digit);

  // Marker search, after closing the current number where the byte ends one.
  assign seek_in    = reading ? finish_phase(phase_q) : phase_q;
  assign seek_out   = seek_phase(seek_in, char_q);
  assign new_number = (seek_out == PH_READ_X) || (seek_out == PH_READ_Y) ||
                      (seek_out == PH_READ_Z);

  // Two's complement value of the number being read.
  assign sval = neg_q ? (MANT_W'(0) - {1'b0, acc_q}) : {1'b0, acc_q};

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (s1_fire) begin
      if (char_zero) begin
        phase_d = PH_SLASH;
      end else if (!reading || terminator) begin
        phase_d = seek_out;
      end
    end
  end

  // Number state, held coordinates and result.
  always_comb begin
    acc_d    = acc_q;
    neg_d    = neg_q;
    start_d  = start_q;
    point_d  = point_q;
    frac_d   = frac_q;
    dig_d    = dig_q;
    xm_d     = xm_q;
    xf_d     = xf_q;
    ym_d     = ym_q;
    yf_d     = yf_q;
    flags_d  = flags_q;
    out_xm_d = out_xm_q;
    out_xf_d = out_xf_q;
    out_ym_d = out_ym_q;
    out_yf_d = out_yf_q;
    out_z_d  = out_z_q;
    out_st_d = out_st_q;
    if (s1_fire) begin
      if (char_zero) begin
        // Close the request: a number still open is taken as it stands.
        out_xm_d = (phase_q == PH_READ_X) ? sval : xm_q;
        out_xf_d = (phase_q == PH_READ_X) ? frac_q : xf_q;
        out_ym_d = (phase_q == PH_READ_Y) ? sval : ym_q;
        out_yf_d = (phase_q == PH_READ_Y) ? frac_q : yf_q;
        out_z_d  = ((phase_q == PH_READ_Z) || (phase_q == PH_DONE)) ? sval[Z_W-1:0] : '0;
        out_st_d = flags_q;
        if ((phase_q != PH_READ_Z) && (phase_q != PH_DONE)) begin
          out_st_d[STAT_MISSING] = 1'b1;
        end
        acc_d   = '0;
        neg_d   = 1'b0;
        start_d = 1'b0;
        point_d = 1'b0;
        frac_d  = '0;
        dig_d   = '0;
        xm_d    = '0;
        xf_d    = '0;
        ym_d    = '0;
        yf_d    = '0;
        flags_d = '0;
      end else if (!reading || terminator) begin
        // Store a finished X or Y, then open a number if the byte is a marker.
        if (phase_q == PH_READ_X) begin
          xm_d = sval;
          xf_d = frac_q;
        end
        if (phase_q == PH_READ_Y) begin
          ym_d = sval;
          yf_d = frac_q;
        end
        start_d = 1'b0;
        if (new_number) begin
          acc_d   = '0;
          neg_d   = 1'b0;
          start_d = 1'b1;
          point_d = 1'b0;
          frac_d  = '0;
          dig_d   = '0;
        end
      end else if (sign_take) begin
        neg_d   = 1'b1;
        start_d = 1'b0;
      end else if (point_take) begin
        point_d = 1'b1;
        start_d = 1'b0;
      end else begin
        // Digit: leading zeros ahead of the point are skipped, digits past the limit dropped.
        start_d = 1'b0;
        if (!skip_zero) begin
          if (at_limit) begin
            flags_d[STAT_DROPPED] = 1'b1;
          end else begin
            acc_d = acc_next;
            dig_d = dig_q + CNT_W'(1);
            if (point_q) begin
              frac_d = frac_q + FRAC_W'(1);
            end
          end
        end
      end
    end
  end

  // Register control.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire && char_zero) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SLASH;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      start_q     <= 1'b0;
      point_q     <= 1'b0;
      frac_q      <= '0;
      dig_q       <= '0;
      xm_q        <= '0;
      xf_q        <= '0;
      ym_q        <= '0;
      yf_q        <= '0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      start_q     <= start_d;
      point_q     <= point_d;
      frac_q      <= frac_d;
      dig_q       <= dig_d;
      xm_q        <= xm_d;
      xf_q        <= xf_d;
      ym_q        <= ym_d;
      yf_q        <= yf_d;
      flags_q     <= flags_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_i.char_in;
    end
    out_xm_q <= out_xm_d;
    out_xf_q <= out_xf_d;
    out_ym_q <= out_ym_d;
    out_yf_q <= out_yf_d;
    out_z_q  <= out_z_d;
    out_st_q <= out_st_d;
  end

  // Result channel.
  assign coord_o.valid         = out_valid_q;
  assign coord_o.x_mantissa    = out_xm_q;
  assign coord_o.x_frac_digits = out_xf_q;
  assign coord_o.y_mantissa    = out_ym_q;
  assign coord_o.y_frac_digits = out_yf_q;
  assign coord_o.z_value       = out_z_q;
  assign coord_o.parse_status  = out_st_q;

`ifndef ASSERT_OFF
  // A zero byte always returns the parser to the search for '/'.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && char_zero |=> phase_q == PH_SLASH)
    else $error("parser did not restart after end of request");

  // A result only appears after a zero byte has been processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && char_zero))
    else $error("result appeared without end of request");

  // Fraction digits are a subset of the kept digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(frac_q) <= dig_q)
    else $error("fraction count exceeds digit count");

  // The Z integer never takes a point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_READ_Z |-> !point_q)
    else $error("point seen while reading Z");
`endif

endmodule

// ===== tb/request_coordinate_parser_test.sv =====
// Self-checking testbench for the request coordinate parser.
`timescale 1ns / 1ps

module request_coordinate_parser_test;
  import rcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One coordinate result as it leaves the block.
  typedef struct packed {
    logic [MANT_W-1:0] x_mant;
    logic [FRAC_W-1:0] x_frac;
    logic [MANT_W-1:0] y_mant;
    logic [FRAC_W-1:0] y_frac;
    logic [Z_W-1:0]    z_val;
    logic [STAT_W-1:0] status;
  } coord_t;

  // Tracks the parse of the byte stream and holds the coordinates still owed by the block.
  class coord_tracker;
    phase_e            phase;
    logic [ACC_W-1:0]  acc;
    logic              neg;
    logic              num_start;
    logic              point_seen;
    logic [FRAC_W-1:0] frac_count;
    logic [CNT_W-1:0]  digit_count;
    logic [MANT_W-1:0] x_mant;
    logic [FRAC_W-1:0] x_frac;
    logic [MANT_W-1:0] y_mant;
    logic [FRAC_W-1:0] y_frac;
    logic [STAT_W-1:0] flags;
    coord_t            expected_coords[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase       = PH_SLASH;
      acc         = '0;
      neg         = 1'b0;
      num_start   = 1'b0;
      point_seen  = 1'b0;
      frac_count  = '0;
      digit_count = '0;
      x_mant      = '0;
      x_frac      = '0;
      y_mant      = '0;
      y_frac      = '0;
      flags       = '0;
    endfunction

    function void open_number();
      acc         = '0;
      neg         = 1'b0;
      num_start   = 1'b1;
      point_seen  = 1'b0;
      frac_count  = '0;
      digit_count = '0;
    endfunction

    function logic [MANT_W-1:0] mant_value();
      logic [MANT_W-1:0] m;
      m = {1'b0, acc};
      return neg ? -m : m;
    endfunction

    function logic [Z_W-1:0] z_value();
      logic [Z_W-1:0] z;
      z = acc[Z_W-1:0];
      return neg ? -z : z;
    endfunction

    // Store the number just read and move on to the next marker.
    function void close_number();
      case (phase)
        PH_READ_X: begin
          x_mant = mant_value();
          x_frac = frac_count;
          phase  = PH_SEEK_Y;
        end
        PH_READ_Y: begin
          y_mant = mant_value();
          y_frac = frac_count;
          phase  = PH_SEEK_Z;
        end
        PH_READ_Z: phase = PH_DONE;
        default: ;
      endcase
    endfunction

    function void seek_marker(logic [CHAR_W-1:0] c);
      if (phase == PH_SLASH && c == CHAR_SLASH) begin
        phase = PH_SEEK_X;
      end else if (phase == PH_SEEK_X && c == CHAR_X) begin
        phase = PH_READ_X;
        open_number();
      end else if (phase == PH_SEEK_Y && c == CHAR_Y) begin
        phase = PH_READ_Y;
        open_number();
      end else if (phase == PH_SEEK_Z && c == CHAR_Z) begin
        phase = PH_READ_Z;
        open_number();
      end
    endfunction

    // Advance the parse by one accepted byte; a zero byte owes one coordinate result.
    function void note_char(logic [CHAR_W-1:0] c);
      logic             reading;
      logic [3:0]       d;
      logic [CNT_W-1:0] limit;
      coord_t           r;
      reading = (phase == PH_READ_X || phase == PH_READ_Y || phase == PH_READ_Z);
      if (c == CHAR_NUL) begin
        if (reading) close_number();
        if (phase <= PH_SEEK_Z) flags[STAT_MISSING] = 1'b1;
        r.x_mant = x_mant;
        r.x_frac = x_frac;
        r.y_mant = y_mant;
        r.y_frac = y_frac;
        r.z_val  = (phase == PH_DONE) ? z_value() : '0;
        r.status = flags;
        expected_coords.push_back(r);
        clear();
      end else if (!reading) begin
        seek_marker(c);
      end else if (num_start && c == CHAR_MINUS) begin
        neg       = 1'b1;
        num_start = 1'b0;
      end else begin
        num_start = 1'b0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          d     = 4'(c - CHAR_ZERO);
          limit = (phase == PH_READ_Z) ? MAX_INT_DIGITS : MAX_DIGITS;
          // Leading zeros ahead of the point carry no weight and are not counted.
          if (point_seen || acc != '0 || d != 4'd0) begin
            if (digit_count >= limit) begin
              flags[STAT_DROPPED] = 1'b1;
            end else begin
              acc         = acc * 10 + ACC_W'(d);
              digit_count = digit_count + 1'b1;
              if (point_seen) frac_count = frac_count + 1'b1;
            end
          end
        end else if (c == CHAR_POINT && phase != PH_READ_Z && !point_seen) begin
          point_seen = 1'b1;
        end else begin
          close_number();
          seek_marker(c);
        end
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_coord(coord_t got);
      coord_t want;
      if (expected_coords.size() == 0) begin
        $error("coordinate result with no request pending");
        mismatches++;
        return;
      end
      want = expected_coords.pop_front();
      compare_field("x_mantissa", $signed(want.x_mant), $signed(got.x_mant));
      compare_field("x_frac_digits", want.x_frac, got.x_frac);
      compare_field("y_mantissa", $signed(want.y_mant), $signed(got.y_mant));
      compare_field("y_frac_digits", want.y_frac, got.y_frac);
      compare_field("z_value", $signed(want.z_val), $signed(got.z_val));
      compare_field("parse_status", want.status, got.status);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rcp_char_if  char_if();
  rcp_coord_if coord_if();

  request_coordinate_parser u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .coord_o (coord_if)
  );

  coord_tracker        tracker;
  bit                  quiet;
  logic [CHAR_W-1:0]   req_bytes[$];
  int unsigned         cycles;
  int unsigned         bytes_sent;

  always #2ns clk_i = ~clk_i;

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) tracker.note_char(char_if.char_in);
    if (rst_ni && coord_if.valid && coord_if.ready) begin
      tracker.check_coord({coord_if.x_mantissa, coord_if.x_frac_digits,
                           coord_if.y_mantissa, coord_if.y_frac_digits,
                           coord_if.z_value, coord_if.parse_status});
    end
  end

  // Result side: stalls a random number of cycles once a result shows up.
  initial begin
    int unsigned stall;
    coord_if.ready = 1'b1;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        coord_if.ready <= 1'b0;
        @(posedge clk_i);
        while (!coord_if.valid) @(posedge clk_i);
        repeat (stall) @(negedge clk_i);
        coord_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      while (!(coord_if.valid && coord_if.ready)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Drive one byte after a random gap; returns at the falling edge after acceptance.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_if.valid   <= 1'b1;
    char_if.char_in <= c;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_request();
    while (req_bytes.size() != 0) send_char(req_bytes.pop_front());
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(CHAR_W'(s[i]));
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic void push_digits(int unsigned n);
    repeat (n) req_bytes.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
  endfunction

  // Append a number: optional sign, leading zeros, integer digits and, for X and Y,
  // an optional fraction. Long digit runs are rare and can overflow the digit limit.
  function automatic void push_number(bit with_point);
    int unsigned pick;
    if ($urandom_range(0, 2) == 0) req_bytes.push_back(CHAR_MINUS);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) req_bytes.push_back(CHAR_ZERO);
    pick = $urandom_range(0, 9);
    if (pick == 0) push_digits(0);
    else if (pick <= 7) push_digits($urandom_range(1, 6));
    else push_digits($urandom_range(7, with_point ? 18 : 12));
    if ($urandom_range(0, 2) != 0 && (with_point || $urandom_range(0, 3) == 0)) begin
      req_bytes.push_back(CHAR_POINT);
      if (with_point) begin
        push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) :
                                                  $urandom_range(0, 6));
        if ($urandom_range(0, 7) == 0) req_bytes.push_back(CHAR_POINT);
      end
    end
  endfunction

  // Mostly well-formed requests with random content; some are noisy or cut short.
  function automatic void build_request();
    repeat ($urandom_range(0, 2)) req_bytes.push_back(noise_char());
    if ($urandom_range(0, 9) != 0) req_bytes.push_back(CHAR_SLASH);
    if ($urandom_range(0, 3) == 0) req_bytes.push_back(noise_char());
    req_bytes.push_back(CHAR_X);
    push_number(1'b1);
    if ($urandom_range(0, 3) == 0) req_bytes.push_back(noise_char());
    req_bytes.push_back(CHAR_Y);
    push_number(1'b1);
    if ($urandom_range(0, 3) == 0) req_bytes.push_back(noise_char());
    req_bytes.push_back(CHAR_Z);
    push_number(1'b0);
    repeat ($urandom_range(0, 2)) req_bytes.push_back(noise_char());
    if ($urandom_range(0, 5) == 0) begin
      int unsigned keep;
      keep = $urandom_range(0, req_bytes.size() - 1);
      while (req_bytes.size() > keep) void'(req_bytes.pop_back());
    end
    req_bytes.push_back(CHAR_NUL);
  endfunction

  // Reset, directed requests, random requests, then drain and report.
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    char_if.valid   = 1'b0;
    char_if.char_in = '0;
    quiet           = 1'b0;
    cycles          = 0;
    bytes_sent      = 0;
    tracker         = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Top byte value and an empty request: no slash, every marker missing.
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(CHAR_NUL);
    // Leading zeros, fraction, bare sign on Y, a trailing byte after Z.
    push_text("a/X00.50Y-Z9!");
    req_bytes.push_back(CHAR_NUL);
    // Empty X and Y, and one digit too many on Z.
    push_text("/XYZ1234567891");
    req_bytes.push_back(CHAR_NUL);
    send_request();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      build_request();
      send_request();
    end
    quiet = 1'b0;
    char_if.valid <= 1'b0;

    while (tracker.expected_coords.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rcp_pkg.sv
rtl/core/rcp_char_if.sv
rtl/core/rcp_coord_if.sv
rtl/core/request_coordinate_parser.sv
tb/request_coordinate_parser_test.sv
